// File: rtl/raster_causal_iir_smoother_top_defines.svh
// ----------------------------------------------------------------------------
// raster_causal_iir_smoother_top_defines
// Assertion macros used by the smoother back engine.
// ----------------------------------------------------------------------------
`ifndef RASTER_CAUSAL_IIR_SMOOTHER_TOP_DEFINES_SVH
`define RASTER_CAUSAL_IIR_SMOOTHER_TOP_DEFINES_SVH

// same-cycle implication, disabled in reset
`define RCIS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define RCIS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/rcis_pkg.sv
// ----------------------------------------------------------------------------
// rcis_pkg
// Types, constants and the blend function of the raster IIR smoother.
// ----------------------------------------------------------------------------
`default_nettype none

package rcis_pkg;

    localparam int HEIGHT_W   = 20;
    localparam int RMAX_W     = 19;
    localparam int K_W        = 9;
    localparam int FW_W       = 11;
    localparam int FH_W       = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [K_W-1:0]  K_ONE    = 9'd256;
    localparam logic [K_W-1:0]  K_RESET  = 9'd192;
    localparam logic [FW_W-1:0] FW_RESET = 11'd1024;
    localparam logic [FH_W-1:0] FH_RESET = 16'd1024;

    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_K      = 2'd0,
        CFG_WIDTH  = 2'd1,
        CFG_HEIGHT = 2'd2
    } t_cfg_reg;

    typedef enum logic [1:0] {
        BK_CLEAR = 2'd0,
        BK_HORIZ = 2'd1,
        BK_VERT  = 2'd2
    } t_back_state;

    typedef struct packed {
        logic first_col;
        logic first_row;
        logic frame_end;
    } t_flags;

    // floor((prev*(256-k) + cur*k) / 256) = prev + floor((cur-prev)*k / 256)
    function automatic logic signed [HEIGHT_W-1:0] blend(
        input logic signed [HEIGHT_W-1:0] prev,
        input logic signed [HEIGHT_W-1:0] cur,
        input logic        [K_W-1:0]      k
    );
        logic signed [HEIGHT_W:0]   diff;
        logic signed [HEIGHT_W+10:0] prod;
        logic signed [HEIGHT_W+10:0] sum;
        diff = {cur[HEIGHT_W-1], cur} - {prev[HEIGHT_W-1], prev};
        prod = diff * $signed({1'b0, k});
        sum  = (HEIGHT_W+11)'(prev) + (prod >>> 8);
        return sum[HEIGHT_W-1:0];
    endfunction

endpackage

`default_nettype wire

// File: rtl/raster_causal_iir_smoother_top.sv
// A sample goes through the queue and the back engine's horizontal and
// vertical steps into the result register. The two blends share one
// multiplier in turn, so no new sample is taken until the vertical step is
// done. Reset: configuration returns to k=192, width=1024, height=1024; full
// stays high while the line store is cleared to zero.
// ----------------------------------------------------------------------------
// raster_causal_iir_smoother_top
// Causal separable first-order IIR smoother for a raster height stream.
// ----------------------------------------------------------------------------
`default_nettype none

module raster_causal_iir_smoother_top #(
    parameter int MAX_WIDTH = 1024
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   push,
    output logic                                        full,
    input  wire logic signed [rcis_pkg::HEIGHT_W-1:0]   i_height_in,
    output logic                                        empty,
    input  wire logic                                   pop,
    output logic signed [rcis_pkg::HEIGHT_W-1:0]        o_height_out,
    output logic [rcis_pkg::RMAX_W-1:0]                 o_running_max,
    output logic                                        o_frame_end,
    input  wire logic                                   i_cfg_valid,
    output logic                                        o_cfg_ready,
    input  wire logic [rcis_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  wire logic [rcis_pkg::CFG_DATA_W-1:0]        i_cfg_data
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int LW = (CW + 1 > rcis_pkg::FW_W) ? CW + 1 : rcis_pkg::FW_W;
    localparam int QW = rcis_pkg::HEIGHT_W + CW + $bits(rcis_pkg::t_flags);

    logic [rcis_pkg::K_W-1:0]  r_k;
    logic [rcis_pkg::FW_W-1:0] r_fw;
    logic [rcis_pkg::FH_W-1:0] r_fh;

    logic [rcis_pkg::K_W-1:0]  k_eff;
    logic [LW-1:0]             fw_ext, width_wide;
    logic [CW:0]               width_eff;
    logic [rcis_pkg::FH_W-1:0] rows_eff;

    logic                      q_push, q_full, q_pop, q_empty, clearing;
    logic signed [rcis_pkg::HEIGHT_W-1:0] f_height, b_height;
    logic [CW-1:0]             f_col, b_col;
    rcis_pkg::t_flags          f_flags, b_flags;
    logic [QW-1:0]             q_wdata, q_rdata;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k  <= rcis_pkg::K_RESET;
            r_fw <= rcis_pkg::FW_RESET;
            r_fh <= rcis_pkg::FH_RESET;
        end else if (i_cfg_valid) begin
            case (rcis_pkg::t_cfg_reg'(i_cfg_index))
                rcis_pkg::CFG_K:      r_k  <= i_cfg_data[rcis_pkg::K_W-1:0];
                rcis_pkg::CFG_WIDTH:  r_fw <= i_cfg_data[rcis_pkg::FW_W-1:0];
                rcis_pkg::CFG_HEIGHT: r_fh <= i_cfg_data[rcis_pkg::FH_W-1:0];
                default: ;
            endcase
        end
    end

    // out-of-range settings saturate
    assign k_eff      = (r_k > rcis_pkg::K_ONE) ? rcis_pkg::K_ONE : r_k;
    assign fw_ext     = LW'(r_fw);
    assign width_wide = (r_fw == '0) ? LW'(1) :
                        (fw_ext > LW'(MAX_WIDTH)) ? LW'(MAX_WIDTH) : fw_ext;
    assign width_eff  = width_wide[CW:0];
    assign rows_eff   = (r_fh == '0) ? rcis_pkg::FH_W'(1) : r_fh;

    rcis_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_full      (full),
        .i_height    (i_height_in),
        .i_width_eff (width_eff),
        .i_rows_eff  (rows_eff),
        .i_clearing  (clearing),
        .i_q_full    (q_full),
        .o_q_push    (q_push),
        .o_q_height  (f_height),
        .o_q_col     (f_col),
        .o_q_flags   (f_flags)
    );

    assign q_wdata = {f_height, f_col, f_flags};

    rcis_queue #(
        .WIDTH (QW)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wdata),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (q_rdata),
        .o_empty (q_empty)
    );

    assign {b_height, b_col, b_flags} = q_rdata;

    rcis_back #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_k_eff       (k_eff),
        .i_q_empty     (q_empty),
        .i_q_height    (b_height),
        .i_q_col       (b_col),
        .i_q_flags     (b_flags),
        .o_q_pop       (q_pop),
        .o_clearing    (clearing),
        .i_out_pop     (pop),
        .o_out_empty   (empty),
        .o_height      (o_height_out),
        .o_running_max (o_running_max),
        .o_frame_end   (o_frame_end)
    );

endmodule

`default_nettype wire

// File: rtl/rcis_ram.sv
// ----------------------------------------------------------------------------
// rcis_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module rcis_ram #(
    parameter int WIDTH = 20,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: rtl/rcis_queue.sv
// ----------------------------------------------------------------------------
// rcis_queue
// Two-entry queue between the front and the back engine.
// ----------------------------------------------------------------------------
`default_nettype none

module rcis_queue #(
    parameter int WIDTH = 33
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic      [WIDTH-1:0] o_data,
    output logic                  o_empty
);

    localparam int PW = $clog2(rcis_pkg::QUEUE_DEPTH);
    localparam int CNTW = $clog2(rcis_pkg::QUEUE_DEPTH + 1);

    logic [WIDTH-1:0] r_data [rcis_pkg::QUEUE_DEPTH];
    logic [PW-1:0]    r_wptr, n_wptr;
    logic [PW-1:0]    r_rptr, n_rptr;
    logic [CNTW-1:0]  r_count, n_count;
    logic             push_ok, pop_ok;

    assign o_full  = (r_count == CNTW'(rcis_pkg::QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign push_ok = i_push && !o_full;
    assign pop_ok  = i_pop && !o_empty;
    assign o_data  = r_data[r_rptr];

    always_comb begin
        n_wptr  = push_ok ? PW'(r_wptr + 1'b1) : r_wptr;
        n_rptr  = pop_ok ? PW'(r_rptr + 1'b1) : r_rptr;
        n_count = r_count;
        if (push_ok && !pop_ok) begin
            n_count = CNTW'(r_count + 1'b1);
        end else if (pop_ok && !push_ok) begin
            n_count = CNTW'(r_count - 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_data[r_wptr] <= i_data;
        end
    end

endmodule

`default_nettype wire

// File: rtl/rcis_front.sv
// ----------------------------------------------------------------------------
// rcis_front
// Accepts samples, tracks raster position and tags each sample.
// ----------------------------------------------------------------------------
`default_nettype none

module rcis_front #(
    parameter int MAX_WIDTH = 1024
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_push,
    output logic                                     o_full,
    input  wire logic signed [rcis_pkg::HEIGHT_W-1:0] i_height,
    input  wire logic [$clog2(MAX_WIDTH):0]          i_width_eff,
    input  wire logic [rcis_pkg::FH_W-1:0]           i_rows_eff,
    input  wire logic                                i_clearing,
    input  wire logic                                i_q_full,
    output logic                                     o_q_push,
    output logic signed [rcis_pkg::HEIGHT_W-1:0]     o_q_height,
    output logic [$clog2(MAX_WIDTH)-1:0]             o_q_col,
    output rcis_pkg::t_flags                         o_q_flags
);

    localparam int CW = $clog2(MAX_WIDTH);

    logic [CW-1:0]             r_col_cnt, n_col_cnt;
    logic [rcis_pkg::FH_W-1:0] r_row_cnt, n_row_cnt;
    logic [CW:0]               width_m1;
    logic [rcis_pkg::FH_W-1:0] rows_m1;
    logic                      last_col, last_row, accept;
    logic [CW-1:0]             col;

    assign o_full   = i_q_full || i_clearing;
    assign accept   = i_push && !o_full;
    assign width_m1 = i_width_eff - 1'b1;
    assign rows_m1  = i_rows_eff - 1'b1;
    // counters left past the edge by a register write count as the last position
    assign last_col = ({1'b0, r_col_cnt} >= width_m1);
    assign last_row = (r_row_cnt >= rows_m1);
    assign col      = last_col ? width_m1[CW-1:0] : r_col_cnt;

    assign o_q_push             = accept;
    assign o_q_height           = i_height;
    assign o_q_col              = col;
    assign o_q_flags.first_col  = (col == '0);
    assign o_q_flags.first_row  = (r_row_cnt == '0);
    assign o_q_flags.frame_end  = last_col && last_row;

    always_comb begin
        n_col_cnt = r_col_cnt;
        n_row_cnt = r_row_cnt;
        if (accept) begin
            if (last_col) begin
                n_col_cnt = '0;
                n_row_cnt = last_row ? '0 : rcis_pkg::FH_W'(r_row_cnt + 1'b1);
            end else begin
                n_col_cnt = CW'(col + 1'b1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_cnt <= '0;
            r_row_cnt <= '0;
        end else begin
            r_col_cnt <= n_col_cnt;
            r_row_cnt <= n_row_cnt;
        end
    end

endmodule

`default_nettype wire

// File: rtl/rcis_back.sv
// ----------------------------------------------------------------------------
// rcis_back
// Back engine: horizontal then vertical blend on one shared multiplier,
// line store access, running maximum and result register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "raster_causal_iir_smoother_top_defines.svh"

module rcis_back #(
    parameter int MAX_WIDTH = 1024
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic [rcis_pkg::K_W-1:0]             i_k_eff,
    input  wire logic                                 i_q_empty,
    input  wire logic signed [rcis_pkg::HEIGHT_W-1:0] i_q_height,
    input  wire logic [$clog2(MAX_WIDTH)-1:0]         i_q_col,
    input  wire rcis_pkg::t_flags                     i_q_flags,
    output logic                                      o_q_pop,
    output logic                                      o_clearing,
    input  wire logic                                 i_out_pop,
    output logic                                      o_out_empty,
    output logic signed [rcis_pkg::HEIGHT_W-1:0]      o_height,
    output logic [rcis_pkg::RMAX_W-1:0]               o_running_max,
    output logic                                      o_frame_end
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int HW = rcis_pkg::HEIGHT_W;

    rcis_pkg::t_back_state r_state, n_state;

    logic [CW-1:0]         r_clr_addr;
    logic signed [HW-1:0]  r_left;
    logic signed [HW-1:0]  r_max;
    logic signed [HW-1:0]  r_h;
    logic [CW-1:0]         r_col;
    rcis_pkg::t_flags      r_flags;
    logic                  r_out_valid;
    logic signed [HW-1:0]  r_out_height;
    logic [rcis_pkg::RMAX_W-1:0] r_out_max;
    logic                  r_out_fend;

    logic                  start;
    logic                  clr_done;
    logic                  ram_we;
    logic [CW-1:0]         ram_waddr;
    logic signed [HW-1:0]  ram_wdata;
    logic signed [HW-1:0]  ram_rdata;
    logic signed [HW-1:0]  mix_prev, mix_cur, mix;
    logic signed [HW-1:0]  h, v, max_h, max_v;

    // next item may start once the result slot is free by the next edge
    assign start    = !i_q_empty && (!r_out_valid || i_out_pop);
    assign clr_done = (r_clr_addr == CW'(MAX_WIDTH - 1));

    always_comb begin
        n_state = r_state;
        case (r_state)
            rcis_pkg::BK_CLEAR: if (clr_done) n_state = rcis_pkg::BK_HORIZ;
            rcis_pkg::BK_HORIZ: if (start) n_state = rcis_pkg::BK_VERT;
            rcis_pkg::BK_VERT:  n_state = rcis_pkg::BK_HORIZ;
            default:            n_state = rcis_pkg::BK_CLEAR;
        endcase
    end

    always_comb begin
        o_q_pop    = 1'b0;
        o_clearing = 1'b0;
        ram_we     = 1'b0;
        ram_waddr  = r_col;
        ram_wdata  = v;
        mix_prev   = r_left;
        mix_cur    = i_q_height;
        case (r_state)
            rcis_pkg::BK_CLEAR: begin
                o_clearing = 1'b1;
                ram_we     = 1'b1;
                ram_waddr  = r_clr_addr;
                ram_wdata  = '0;
            end
            rcis_pkg::BK_HORIZ: begin
                o_q_pop = start;
            end
            rcis_pkg::BK_VERT: begin
                ram_we   = 1'b1;
                mix_prev = ram_rdata;
                mix_cur  = r_h;
            end
            default: begin
                o_clearing = 1'b1;
            end
        endcase
    end

    assign mix   = rcis_pkg::blend(mix_prev, mix_cur, i_k_eff);
    assign h     = i_q_flags.first_col ? i_q_height : mix;
    assign max_h = (!i_q_flags.first_col && (h > r_max)) ? h : r_max;
    assign v     = r_flags.first_row ? r_h : mix;
    assign max_v = (!r_flags.first_row && (v > r_max)) ? v : r_max;

    rcis_ram #(
        .WIDTH (HW),
        .DEPTH (MAX_WIDTH)
    ) u_line_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (i_q_col),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rcis_pkg::BK_CLEAR;
            r_clr_addr  <= '0;
            r_left      <= '0;
            r_max       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == rcis_pkg::BK_CLEAR) begin
                r_clr_addr <= CW'(r_clr_addr + 1'b1);
            end
            if (r_state == rcis_pkg::BK_HORIZ && start) begin
                r_left <= h;
                r_max  <= max_h;
            end
            if (r_state == rcis_pkg::BK_VERT) begin
                r_max       <= r_flags.frame_end ? '0 : max_v;
                r_out_valid <= 1'b1;
            end else if (i_out_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == rcis_pkg::BK_HORIZ && start) begin
            r_h     <= h;
            r_col   <= i_q_col;
            r_flags <= i_q_flags;
        end
        if (r_state == rcis_pkg::BK_VERT) begin
            r_out_height <= v;
            r_out_max    <= max_v[rcis_pkg::RMAX_W-1:0];
            r_out_fend   <= r_flags.frame_end;
        end
    end

    assign o_out_empty   = !r_out_valid;
    assign o_height      = r_out_height;
    assign o_running_max = r_out_max;
    assign o_frame_end   = r_out_fend;

    `RCIS_ASSERT_NOW(a_no_pop_in_clear, r_state == rcis_pkg::BK_CLEAR, !o_q_pop,
        "item taken from queue during line store clear")
    `RCIS_ASSERT_NOW(a_slot_free, r_state == rcis_pkg::BK_VERT, !r_out_valid,
        "result slot still occupied when result is produced")
    `RCIS_ASSERT_NEXT(a_vert_done, r_state == rcis_pkg::BK_VERT,
        r_state == rcis_pkg::BK_HORIZ && r_out_valid, "vertical step did not complete")
    `RCIS_ASSERT_NOW(a_max_floor, r_out_valid, !r_max[HW-1],
        "running maximum went negative")

endmodule

`default_nettype wire

// File: tb/raster_causal_iir_smoother_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// raster_causal_iir_smoother_top_test
// Self-checking bench for the raster IIR smoother. A short scripted sequence
// hits the register corner cases and field extremes, then randomized phases
// stream heights under several frame shapes, weights and idle patterns.
// Results are checked against typed values or a model of the two blend stages.
// ----------------------------------------------------------------------------

module raster_causal_iir_smoother_top_test;

    localparam int MAX_WIDTH   = 1024;
    localparam int PHASES      = 12;
    localparam int WIDE_PHASE  = 9;
    localparam int HOLD_PHASE  = 4;
    localparam int PAUSE_PHASE = 6;
    localparam int HOLD_CYCLES = 300;

    localparam logic [rcis_pkg::CFG_IDX_W-1:0] CFG_NONE = 2'd3;   // unmapped index

    localparam logic signed [rcis_pkg::HEIGHT_W-1:0] HEIGHT_MAX = 20'sh7FFFF;
    localparam logic signed [rcis_pkg::HEIGHT_W-1:0] HEIGHT_MIN = 20'sh80000;

    typedef struct packed {
        logic [rcis_pkg::HEIGHT_W-1:0] height;
        logic [rcis_pkg::RMAX_W-1:0]   peak;
        logic                          frame_end;
    } t_smooth_result;

    typedef enum logic { ROW_SAMPLE, ROW_WRITE } t_row_kind;

    typedef struct packed {
        t_row_kind                      kind;
        logic [rcis_pkg::CFG_IDX_W-1:0] idx;
        logic [rcis_pkg::HEIGHT_W-1:0]  value;
        logic                           typed;
        t_smooth_result                 want;
    } t_script_row;

    logic                                  i_clk;
    logic                                  i_rst_n       = 1'b0;
    logic                                  push          = 1'b0;
    logic signed [rcis_pkg::HEIGHT_W-1:0]  i_height_in   = '0;
    logic                                  pop           = 1'b0;
    logic                                  i_cfg_valid   = 1'b0;
    logic [rcis_pkg::CFG_IDX_W-1:0]        i_cfg_index   = '0;
    logic [rcis_pkg::CFG_DATA_W-1:0]       i_cfg_data    = '0;
    logic                                  full;
    logic                                  empty;
    logic signed [rcis_pkg::HEIGHT_W-1:0]  o_height_out;
    logic [rcis_pkg::RMAX_W-1:0]           o_running_max;
    logic                                  o_frame_end;
    logic                                  o_cfg_ready;

    // sideband riding along with push: a hand-typed expectation
    logic                        drv_typed     = 1'b0;
    t_smooth_result              drv_expect    = '0;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_len       = 0;

    // model state
    logic [rcis_pkg::K_W-1:0]              k_reg      = rcis_pkg::K_RESET;
    logic [rcis_pkg::FW_W-1:0]             width_reg  = rcis_pkg::FW_RESET;
    logic [rcis_pkg::FH_W-1:0]             height_reg = rcis_pkg::FH_RESET;
    logic signed [rcis_pkg::HEIGHT_W-1:0]  line_mem [MAX_WIDTH];
    logic signed [rcis_pkg::HEIGHT_W-1:0]  left_h     = '0;
    logic signed [rcis_pkg::HEIGHT_W-1:0]  peak       = '0;
    int unsigned                           col_pos    = 0;
    int unsigned                           row_pos    = 0;

    t_smooth_result pending_q [$];

    int errors      = 0;
    int samples_in  = 0;
    int results_in  = 0;
    int frame_ends  = 0;
    int cfg_writes  = 0;

    raster_causal_iir_smoother_top #(
        .MAX_WIDTH     (MAX_WIDTH)
    ) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .push          (push),
        .full          (full),
        .i_height_in   (i_height_in),
        .empty         (empty),
        .pop           (pop),
        .o_height_out  (o_height_out),
        .o_running_max (o_running_max),
        .o_frame_end   (o_frame_end),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin : watchdog
        #5_000_000;
        $display("timeout: stream did not drain, %0d results outstanding", pending_q.size());
        $display("FAIL");
        $finish;
    end

    // floor((prev*(1-k) + cur*k)) with k in Q1.8
    function automatic logic signed [rcis_pkg::HEIGHT_W-1:0] iir_mix(
        input logic signed [rcis_pkg::HEIGHT_W-1:0] prev,
        input logic signed [rcis_pkg::HEIGHT_W-1:0] cur,
        input int unsigned                          k
    );
        longint acc;
        acc = longint'(prev) * longint'(256 - k) + longint'(cur) * longint'(k);
        return rcis_pkg::HEIGHT_W'(acc >>> 8);
    endfunction

    function automatic t_smooth_result smooth_sample(
        input logic signed [rcis_pkg::HEIGHT_W-1:0] x
    );
        t_smooth_result                        r;
        int unsigned                           k;
        int unsigned                           w;
        int unsigned                           rows;
        int unsigned                           col;
        logic                                  last_col;
        logic                                  last_row;
        logic signed [rcis_pkg::HEIGHT_W-1:0]  h;
        logic signed [rcis_pkg::HEIGHT_W-1:0]  v;
        k    = (k_reg > rcis_pkg::K_ONE) ? rcis_pkg::K_ONE : k_reg;
        w    = (width_reg == 0) ? 1 : width_reg;
        if (w > MAX_WIDTH) w = MAX_WIDTH;
        rows = (height_reg == 0) ? 1 : height_reg;
        // a shrunk frame leaves counters past the end: treat as last position
        last_col = (col_pos >= w - 1);
        last_row = (row_pos >= rows - 1);
        col      = last_col ? w - 1 : col_pos;

        if (col == 0) begin
            h = x;
        end else begin
            h = iir_mix(left_h, x, k);
            if (h > peak) peak = h;
        end
        left_h = h;

        if (row_pos == 0) begin
            v = h;
        end else begin
            v = iir_mix(line_mem[col], h, k);
            if (v > peak) peak = v;
        end
        line_mem[col] = v;

        r.height    = v;
        r.peak      = peak[rcis_pkg::RMAX_W-1:0];
        r.frame_end = last_col && last_row;

        if (last_col) begin
            col_pos = 0;
            if (last_row) begin
                row_pos = 0;
                peak    = '0;
            end else begin
                row_pos = (row_pos + 1) & 32'hFFFF;
            end
        end else begin
            col_pos = col + 1;
        end
        return r;
    endfunction

    function automatic void report_field(input string field, input int expected,
                                         input int actual);
        if (expected != actual) begin
            errors++;
            $display("%0t mismatch on %s: expected %0d, actual %0d",
                     $time, field, expected, actual);
        end
    endfunction

    // scoreboard: everything sampled at the edge, before the edge's updates land
    always @(posedge i_clk) begin : monitor
        t_smooth_result want_r;
        t_smooth_result got_r;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    rcis_pkg::CFG_K:      k_reg      = i_cfg_data[rcis_pkg::K_W-1:0];
                    rcis_pkg::CFG_WIDTH:  width_reg  = i_cfg_data[rcis_pkg::FW_W-1:0];
                    rcis_pkg::CFG_HEIGHT: height_reg = i_cfg_data[rcis_pkg::FH_W-1:0];
                    default: ;
                endcase
            end
            if (push && !full) begin
                want_r = smooth_sample(i_height_in);
                if (drv_typed) want_r = drv_expect;
                pending_q.push_back(want_r);
                samples_in++;
            end
            if (pop && !empty) begin
                got_r = '{o_height_out, o_running_max, o_frame_end};
                results_in++;
                if (o_frame_end) frame_ends++;
                if (pending_q.size() == 0) begin
                    errors++;
                    $display("%0t mismatch: expected no result transfer, actual %0d",
                             $time, o_height_out);
                end else begin
                    want_r = pending_q.pop_front();
                    report_field("height_out", int'($signed(want_r.height)),
                                 int'($signed(got_r.height)));
                    report_field("running_max", int'(want_r.peak), int'(got_r.peak));
                    report_field("frame_end", int'(want_r.frame_end), int'(got_r.frame_end));
                end
            end
        end
    end

    initial begin : result_sink
        forever begin
            @(posedge i_clk);
            if (hold_len > 0) begin
                hold_len--;
                pop <= 1'b0;
            end else begin
                pop <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    task automatic send_sample(input logic [rcis_pkg::HEIGHT_W-1:0] x, input logic typed,
                               input t_smooth_result want);
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push        <= 1'b1;
        i_height_in <= x;
        drv_typed   <= typed;
        drv_expect  <= want;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
    endtask

    task automatic wait_drained();
        push <= 1'b0;
        @(posedge i_clk);
        while (pending_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [rcis_pkg::CFG_IDX_W-1:0] idx,
                             input logic [rcis_pkg::CFG_DATA_W-1:0] data);
        wait_drained();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        cfg_writes++;
    endtask

    function automatic t_script_row sample_row(input int x);
        t_script_row r;
        r       = '0;
        r.kind  = ROW_SAMPLE;
        r.value = rcis_pkg::HEIGHT_W'(x);
        return r;
    endfunction

    function automatic t_script_row checked_row(input int x, input int out_v,
                                                input int max_v, input logic fend);
        t_script_row r;
        r       = sample_row(x);
        r.typed = 1'b1;
        r.want  = '{rcis_pkg::HEIGHT_W'(out_v), rcis_pkg::RMAX_W'(max_v), fend};
        return r;
    endfunction

    function automatic t_script_row write_row(input logic [rcis_pkg::CFG_IDX_W-1:0] idx,
                                              input int data);
        t_script_row r;
        r       = '0;
        r.kind  = ROW_WRITE;
        r.idx   = idx;
        r.value = rcis_pkg::HEIGHT_W'(data);
        return r;
    endfunction

    function automatic logic signed [rcis_pkg::HEIGHT_W-1:0] rand_height();
        case ($urandom_range(9))
            0:       return HEIGHT_MIN;
            1:       return HEIGHT_MAX;
            2, 3:    return rcis_pkg::HEIGHT_W'(int'($urandom_range(4000)) - 2000);
            default: return rcis_pkg::HEIGHT_W'($urandom);
        endcase
    endfunction

    initial begin : stimulus
        t_script_row                     script [$];
        logic [rcis_pkg::CFG_DATA_W-1:0] k_data;
        logic [rcis_pkg::CFG_DATA_W-1:0] w_data;
        logic [rcis_pkg::CFG_DATA_W-1:0] h_data;
        int                              n;
        foreach (line_mem[i]) line_mem[i] = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset defaults: k=192, 1024 x 1024
        script.push_back(checked_row(-524288, -524288, 0, 1'b0));
        script.push_back(sample_row(524287));
        script.push_back(sample_row(0));
        script.push_back(write_row(rcis_pkg::CFG_K, 256));
        script.push_back(checked_row(524287, 524287, 524287, 1'b0));
        // shrink the frame while the column counter is already past it
        script.push_back(write_row(rcis_pkg::CFG_WIDTH, 2));
        script.push_back(write_row(rcis_pkg::CFG_HEIGHT, 2));
        script.push_back(checked_row(-1, -1, 524287, 1'b0));
        script.push_back(sample_row(1000));
        script.push_back(sample_row(2000));
        // k above one, upper data bits set
        script.push_back(write_row(rcis_pkg::CFG_K, 16'hFFFF));
        script.push_back(checked_row(300, 300, 0, 1'b0));
        script.push_back(checked_row(-300, -300, 0, 1'b0));
        script.push_back(write_row(rcis_pkg::CFG_K, 0));
        script.push_back(sample_row(777));
        script.push_back(sample_row(524287));
        // zero width and height act as one: every sample ends a frame
        script.push_back(write_row(rcis_pkg::CFG_WIDTH, 0));
        script.push_back(write_row(rcis_pkg::CFG_HEIGHT, 0));
        script.push_back(checked_row(524287, 524287, 0, 1'b1));
        script.push_back(checked_row(-524288, -524288, 0, 1'b1));
        // oversized width clamps to the line store size
        script.push_back(write_row(rcis_pkg::CFG_WIDTH, 16'hFFFF));
        script.push_back(write_row(rcis_pkg::CFG_HEIGHT, 16'hFFFF));
        script.push_back(write_row(CFG_NONE, 0));
        script.push_back(checked_row(12345, 12345, 0, 1'b0));
        script.push_back(write_row(rcis_pkg::CFG_K, 128));
        script.push_back(sample_row(100));

        foreach (script[i]) begin
            if (script[i].kind == ROW_WRITE)
                write_reg(script[i].idx, script[i].value[rcis_pkg::CFG_DATA_W-1:0]);
            else
                send_sample(script[i].value, script[i].typed, script[i].want);
        end

        for (int ph = 0; ph < PHASES; ph++) begin
            case ($urandom_range(4))
                0:       k_data = 16'd0;
                1:       k_data = 16'(rcis_pkg::K_ONE);
                2:       k_data = 16'($urandom_range(257, 511)) | (16'($urandom) & 16'hFE00);
                default: k_data = 16'($urandom_range(1, 255));
            endcase
            case ($urandom_range(7))
                0:       w_data = 16'd0;
                1:       w_data = 16'($urandom_range(13, 40));
                default: w_data = 16'($urandom_range(1, 12));
            endcase
            case ($urandom_range(7))
                0:       h_data = 16'd0;
                1:       h_data = 16'hFFFF;
                default: h_data = 16'($urandom_range(1, 6));
            endcase
            if (ph == WIDE_PHASE) begin
                w_data = 16'(MAX_WIDTH);
                h_data = 16'd2;
            end
            // bits above the register width must be dropped
            w_data = w_data | (16'($urandom) & 16'hF800);
            write_reg(rcis_pkg::CFG_K, k_data);
            write_reg(rcis_pkg::CFG_WIDTH, w_data);
            write_reg(rcis_pkg::CFG_HEIGHT, h_data);
            if ($urandom_range(3) == 0) write_reg(CFG_NONE, 16'($urandom));

            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 66; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 66; end
                default: begin send_idle_pct = 19; recv_stall_pct = 19; end
            endcase
            // long receiver hold-off: the block fills and backs up the input
            if (ph == HOLD_PHASE) hold_len = HOLD_CYCLES;

            n = (ph == WIDE_PHASE) ? 200 : $urandom_range(90, 130);
            for (int i = 0; i < n; i++) begin
                if (ph == PAUSE_PHASE && i == n / 2) wait_drained();
                send_sample(rand_height(), 1'b0, '0);
            end
        end

        wait_drained();
        repeat (8) @(posedge i_clk);

        $display("streamed %0d samples, checked %0d results, %0d frame ends seen",
                 samples_in, results_in, frame_ends);
        $display("%0d register writes over %0d random phases plus the scripted corners",
                 cfg_writes, PHASES);
        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
